FILE: hw/rtl/rhc_pkg.sv
// shared widths, codes and the pipeline item type for the rgb to hsv converter
// no dependencies; imported by every module of the block
package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_W        = 9;
    localparam int SAT_W        = 8;

    // quotient bits retired per divider stage, and stage count
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = 3;
    localparam int QW         = DIV_STEP * DIV_STAGES;

    // hue numerator is below 421 * span, so it fits channel width plus quotient width
    localparam int NUM_W = CHANNEL_BITS + QW;

    // front end is two stages, then the divider, then the output register
    localparam int LATENCY = 2 + DIV_STAGES + 1;

    localparam int SAT_SCALE  = 255;
    localparam int DEG_FULL   = 360;
    localparam int DEG_SECTOR = 60;
    localparam int BASE_GREEN = 120;
    localparam int BASE_BLUE  = 240;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    // one pixel in flight through the dividers
    typedef struct packed {
        logic [NUM_W-1:0] rem_h;  // hue partial remainder
        logic [NUM_W-1:0] rem_s;  // saturation partial remainder
        chan_t            div_h;  // span = max - min
        chan_t            div_s;  // max, also the brightness
        logic [QW-1:0]    q_h;
        logic [QW-1:0]    q_s;
        logic             grey;
    } div_item_t;

endpackage

FILE: hw/rtl/rhc_front.sv
// front end: max/min and sector pick, then span and both numerators
// depends on rhc_pkg
module rhc_front
    import rhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  chan_t     red,
    input  chan_t     green,
    input  chan_t     blue,
    output logic      out_valid,
    output div_item_t out_item
);

    localparam int SW = NUM_W + 1;

    // stage one
    logic                      v1_reg;
    chan_t                     max_reg, max_next;
    chan_t                     min_reg, min_next;
    logic [1:0]                sec_reg, sec_next;
    logic signed [CHANNEL_BITS:0] diff_reg, diff_next;

    // stage two
    logic      v2_reg;
    div_item_t item_reg, item_next;

    always_comb
    begin
        max_next = red;
        sec_next = SEC_RED;
        if (green > max_next)
        begin
            max_next = green;
            sec_next = SEC_GREEN;
        end
        if (blue > max_next)
        begin
            max_next = blue;
            sec_next = SEC_BLUE;
        end
        min_next = red;
        if (green < min_next)
            min_next = green;
        if (blue < min_next)
            min_next = blue;
        unique case (sec_next)
            SEC_RED:   diff_next = signed'({1'b0, green}) - signed'({1'b0, blue});
            SEC_GREEN: diff_next = signed'({1'b0, blue}) - signed'({1'b0, red});
            default:   diff_next = signed'({1'b0, red}) - signed'({1'b0, green});
        endcase
    end

    always_comb
    begin
        chan_t                span;
        logic signed [SW-1:0] span_s;
        logic signed [SW-1:0] diff_s;
        logic signed [SW-1:0] base_s;
        logic signed [SW-1:0] num_s;
        logic [NUM_W-1:0]     span_w;
        span   = max_reg - min_reg;
        span_s = signed'(SW'(span));
        diff_s = SW'(diff_reg);
        unique case (sec_reg)
            SEC_RED:   base_s = SW'(DEG_FULL);
            SEC_GREEN: base_s = SW'(BASE_GREEN);
            default:   base_s = SW'(BASE_BLUE);
        endcase
        // never negative: red sector starts at 300 * span at the least
        num_s  = (base_s * span_s) + (SW'(DEG_SECTOR) * diff_s);
        span_w = NUM_W'(span);

        item_next.rem_h = num_s[NUM_W-1:0];
        item_next.rem_s = NUM_W'(span_w * NUM_W'(SAT_SCALE));
        item_next.div_h = span;
        item_next.div_s = max_reg;
        item_next.q_h   = '0;
        item_next.q_s   = '0;
        item_next.grey  = (span == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg  <= max_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        diff_reg <= diff_next;
        item_reg <= item_next;
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

FILE: hw/rtl/rhc_divide.sv
// pipelined restoring division, hue and saturation side by side
// depends on rhc_pkg; each stage retires DIV_STEP quotient bits
module rhc_divide
    import rhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  div_item_t in_item,
    output logic      out_valid,
    output div_item_t out_item
);

    logic      valid_reg [DIV_STAGES];
    div_item_t item_reg  [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic      src_valid;
        div_item_t src_item;
        div_item_t item_next;

        if (g == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_item  = in_item;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[g-1];
            assign src_item  = item_reg[g-1];
        end

        always_comb
        begin
            div_item_t        cur;
            logic [NUM_W-1:0] trial_h;
            logic [NUM_W-1:0] trial_s;
            logic             take_h;
            logic             take_s;
            cur = src_item;
            for (int k = 0; k < DIV_STEP; k++)
            begin
                trial_h = NUM_W'(cur.div_h) << (QW - 1 - g * DIV_STEP - k);
                trial_s = NUM_W'(cur.div_s) << (QW - 1 - g * DIV_STEP - k);
                take_h  = (cur.rem_h >= trial_h);
                take_s  = (cur.rem_s >= trial_s);
                if (take_h)
                    cur.rem_h = cur.rem_h - trial_h;
                if (take_s)
                    cur.rem_s = cur.rem_s - trial_s;
                cur.q_h = {cur.q_h[QW-2:0], take_h};
                cur.q_s = {cur.q_s[QW-2:0], take_s};
            end
            item_next = cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else
                valid_reg[g] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            item_reg[g] <= item_next;
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_item  = item_reg[DIV_STAGES-1];

endmodule

FILE: hw/rtl/rgb_to_hsv_convert.sv
// top level of the rgb to hsv converter: front end, divider, hue wrap and output register
// depends on rhc_pkg, rhc_front and rhc_divide
//
// Takes one pixel per clock: busy is always low, so every cycle with start high
// is a transfer. Each pixel comes out at the end of the pipeline with done
// high for one cycle; the receiver cannot hold results off and must take
// them as they come. The pipeline is two front-end stages (max/min and
// sector, then span and numerators), three divider stages that each retire three
// quotient bits for hue and saturation in parallel, and the output register that
// also wraps hue into 0..359. Grey pixels give hue 0, black pixels give
// saturation 0; all results are rounded down.
module rgb_to_hsv_convert
    import rhc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  chan_t             red,
    input  chan_t             green,
    input  chan_t             blue,
    output logic              done,
    output logic [HUE_W-1:0]  hue,
    output logic [SAT_W-1:0]  saturation,
    output logic [CHANNEL_BITS-1:0] brightness
);

    logic      front_valid;
    div_item_t front_item;
    logic      div_valid;
    div_item_t div_item;

    logic             done_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [SAT_W-1:0] sat_reg, sat_next;
    chan_t            bright_reg;

    // the pipeline never stalls, so a transfer is simply start
    assign busy = 1'b0;

    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    rhc_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // quotient is at most 420, so a single subtract wraps it
    always_comb
    begin
        logic [HUE_W-1:0] q;
        q = div_item.q_h[HUE_W-1:0];
        if (div_item.grey)
            hue_next = '0;
        else if (q >= HUE_W'(DEG_FULL))
            hue_next = q - HUE_W'(DEG_FULL);
        else
            hue_next = q;

        // divide by zero yields all ones, black forces zero
        if (div_item.div_s == '0)
            sat_next = '0;
        else
            sat_next = div_item.q_s[SAT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= div_item.div_s;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

    // a result only ever follows a matching transfer at the pipeline input
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching transfer");

    // a transfer always yields a result
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start ##LATENCY 1'b1 |-> done)
        else $error("transfer lost in pipeline");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue < HUE_W'(DEG_FULL)))
        else $error("hue not wrapped");

    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && brightness == '0) |-> (saturation == '0 && hue == '0))
        else $error("black pixel gave nonzero hue or saturation");

    // brightness carried through the pipeline is not below any input channel
    a_bright_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (brightness >= $past(red, LATENCY) && brightness >= $past(green, LATENCY)
                  && brightness >= $past(blue, LATENCY)))
        else $error("brightness below an input channel");

endmodule

FILE: tb/hsv_pixel_checker.sv
`timescale 1ns / 1ps
// checker for the rgb to hsv converter: watches pixel and result transfers,
// predicts hue, saturation and brightness, and counts mismatches; uses rhc_pkg
module hsv_pixel_checker
    import rhc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  chan_t                   red,
    input  chan_t                   green,
    input  chan_t                   blue,
    input  logic                    done,
    input  logic [HUE_W-1:0]        hue,
    input  logic [SAT_W-1:0]        saturation,
    input  logic [CHANNEL_BITS-1:0] brightness,
    output int                      mismatch_count,
    output int                      pending_count,
    output int                      compared_count
);

    localparam int FULL_TURN  = 360;
    localparam int SECTOR_DEG = 60;
    localparam int GREEN_BASE = 120;
    localparam int BLUE_BASE  = 240;
    localparam int SAT_FULL   = 255;
    localparam int PRINT_CAP  = 20;

    typedef struct packed {
        logic [HUE_W-1:0]        hue;
        logic [SAT_W-1:0]        sat;
        logic [CHANNEL_BITS-1:0] val;
    } hsv_t;

    hsv_t hsv_pending_q[$];

    function automatic hsv_t hsv_from_rgb(chan_t r, chan_t g, chan_t b);
        int   mx;
        int   mn;
        int   span;
        int   numer;
        hsv_t res;
        res = '0;
        mx  = int'(r);
        mn  = int'(r);
        if (int'(g) > mx) mx = int'(g);
        if (int'(b) > mx) mx = int'(b);
        if (int'(g) < mn) mn = int'(g);
        if (int'(b) < mn) mn = int'(b);
        span = mx - mn;
        if (span != 0)
        begin
            // ties go red first, then green
            if (mx == int'(r))
                numer = FULL_TURN * span + SECTOR_DEG * (int'(g) - int'(b));
            else if (mx == int'(g))
                numer = GREEN_BASE * span + SECTOR_DEG * (int'(b) - int'(r));
            else
                numer = BLUE_BASE * span + SECTOR_DEG * (int'(r) - int'(g));
            res.hue = HUE_W'((numer / span) % FULL_TURN);
        end
        if (mx != 0)
            res.sat = SAT_W'((SAT_FULL * span) / mx);
        res.val = CHANNEL_BITS'(mx);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hsv_t want;
        if (!rst_n)
        begin
            hsv_pending_q.delete();
            mismatch_count = 0;
            pending_count  = 0;
            compared_count <= 0;
        end
        else
        begin
            // result side first so a same-cycle pixel never matches itself
            if (done)
            begin
                if (hsv_pending_q.size() == 0)
                    report_mismatch("unexpected result, hue", int'(hue), 0);
                else
                begin
                    want = hsv_pending_q.pop_front();
                    if (hue !== want.hue)
                        report_mismatch("hue", int'(hue), int'(want.hue));
                    if (saturation !== want.sat)
                        report_mismatch("saturation", int'(saturation), int'(want.sat));
                    if (brightness !== want.val)
                        report_mismatch("brightness", int'(brightness), int'(want.val));
                    compared_count <= compared_count + 1;
                end
            end
            if (start && !busy)
                hsv_pending_q.insert(hsv_pending_q.size(), hsv_from_rgb(red, green, blue));
            pending_count = hsv_pending_q.size();
        end
    end

endmodule

FILE: tb/rgb_to_hsv_convert_tb.sv
`timescale 1ns / 1ps
// top of the rgb to hsv converter testbench: clock, reset, pixel stimulus and verdict
// depends on rhc_pkg, rgb_to_hsv_convert and hsv_pixel_checker
module rgb_to_hsv_convert_tb
    import rhc_pkg::*;
;

    localparam int RANDOM_PIXELS = 1400;
    localparam int CYCLE_LIMIT   = 100000;
    // no idling at all while the random pixel index is in this window
    localparam int STEADY_FROM   = 500;
    localparam int STEADY_TO     = 800;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    chan_t                   red;
    chan_t                   green;
    chan_t                   blue;
    logic                    done;
    logic [HUE_W-1:0]        hue;
    logic [SAT_W-1:0]        saturation;
    logic [CHANNEL_BITS-1:0] brightness;

    int  mismatch_count;
    int  pending_count;
    int  compared_count;
    int  pixels_sent;
    int  cycle_count;
    bit  gaps_on;

    rgb_to_hsv_convert i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    hsv_pixel_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .done           (done),
        .hue            (hue),
        .saturation     (saturation),
        .brightness     (brightness),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .compared_count (compared_count)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one pixel transfer; start stays high across back-to-back pixels so it
    // is never lowered and raised in the same time step
    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        bit taken;
        // random idle cycles ahead of the pixel, about 9 in 100
        while (gaps_on && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        // busy only moves on the rising edge, so the falling edge sees what
        // the next rising edge will act on
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        pixels_sent++;
    endtask

    function automatic chan_t near_value(chan_t base);
        int v;
        v = int'(base) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return chan_t'(v);
    endfunction

    // random pixel with a mix of shapes: fully random, two channels tied,
    // grey, channels pinned to the rails, and nearly grey with tiny spans
    task automatic send_random_pixel();
        int    kind;
        chan_t a;
        chan_t c;
        chan_t d;
        kind = $urandom_range(0, 99);
        a    = chan_t'($urandom_range(0, 255));
        c    = chan_t'($urandom_range(0, 255));
        d    = chan_t'($urandom_range(0, 255));
        if (kind < 55)
            send_pixel(a, c, d);
        else if (kind < 70)
        begin
            // two channels equal, exercises the sector tie order
            case ($urandom_range(0, 2))
                0:       send_pixel(a, a, c);
                1:       send_pixel(a, c, a);
                default: send_pixel(c, a, a);
            endcase
        end
        else if (kind < 78)
            send_pixel(a, a, a);
        else if (kind < 90)
        begin
            if ($urandom_range(0, 2) == 0) a = '1;
            if ($urandom_range(0, 2) == 0) c = '0;
            if ($urandom_range(0, 2) == 0) d = ($urandom_range(0, 1) != 0) ? '1 : '0;
            send_pixel(a, c, d);
        end
        else
            send_pixel(a, near_value(a), near_value(a));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        red         = '0;
        green       = '0;
        blue        = '0;
        pixels_sent = 0;
        gaps_on     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: black, white, greys, primaries and secondaries
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        // yellow: red and green tie, red wins and hue wraps to 60
        send_pixel(8'd255, 8'd255, 8'd0);
        // cyan: green and blue tie, green wins
        send_pixel(8'd0,   8'd255, 8'd255);
        // magenta: red and blue tie, red sector with negative offset
        send_pixel(8'd255, 8'd0,   8'd255);
        // red sector just below a full turn
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd10);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd254, 8'd255);
        send_pixel(8'd0,   8'd128, 8'd255);
        send_pixel(8'd255, 8'd128, 8'd0);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd85,  8'd170, 8'd0);
        send_pixel(8'd2,   8'd1,   8'd0);

        // random stream with idling, and a steady stretch without it
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            gaps_on = !(i >= STEADY_FROM && i < STEADY_TO);
            send_random_pixel();
        end
        start <= 1'b0;

        // drain: wait for every expected result, then a short tail
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("covered %0d pixels: directed extremes, ties, greys, rail values,",
                 pixels_sent);
        $display("near-grey spans and random colors; %0d results compared",
                 compared_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
